@@ rtl/rlf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_pkg
// Field types, item kinds, operation codes and status codes shared by the
// replicated log follower modules.
// ----------------------------------------------------------------------------
package rlf_pkg;

  typedef logic [2:0]  kind_t;
  typedef logic [15:0] index_t;
  typedef logic [31:0] term_t;
  typedef logic [31:0] command_t;
  typedef logic [3:0]  status_t;
  typedef logic [10:0] summary_index_t;
  typedef logic [2:0]  op_t;

  localparam kind_t KIND_APPEND = 3'd0;
  localparam kind_t KIND_HEADER = 3'd1;
  localparam kind_t KIND_ENTRY  = 3'd2;
  localparam kind_t KIND_COMMIT = 3'd3;
  localparam kind_t KIND_READ   = 3'd4;

  localparam op_t OP_NONE   = 3'd0;
  localparam op_t OP_APPEND = 3'd1;
  localparam op_t OP_HEADER = 3'd2;
  localparam op_t OP_ENTRY  = 3'd3;
  localparam op_t OP_COMMIT = 3'd4;
  localparam op_t OP_READ   = 3'd5;

  localparam status_t ST_OK              = 4'd0;
  localparam status_t ST_PREV_MISMATCH   = 4'd1;
  localparam status_t ST_INDEX_ZERO      = 4'd2;
  localparam status_t ST_OVERLAP         = 4'd3;
  localparam status_t ST_GAP             = 4'd4;
  localparam status_t ST_REPLACE_COMMIT  = 4'd5;
  localparam status_t ST_COMMIT_BACKWARD = 4'd6;
  localparam status_t ST_COMMIT_PAST     = 4'd7;
  localparam status_t ST_NOT_FOUND       = 4'd8;
  localparam status_t ST_SKIPPED         = 4'd9;
  localparam status_t ST_FULL            = 4'd10;

  // classified item held in the queue between front and back
  typedef struct packed {
    op_t      op;
    logic     idx_zero;
    index_t   log_index;
    index_t   idx_m1;
    term_t    entry_term;
    command_t entry_command;
  } item_t;

endpackage

@@ rtl/rlf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_in_if / rlf_out_if
// Valid/ready channels for log requests and log results.
// ----------------------------------------------------------------------------
interface rlf_in_if;
  import rlf_pkg::*;

  logic     valid;
  logic     ready;
  kind_t    kind;
  index_t   log_index;
  term_t    entry_term;
  command_t entry_command;

  modport source (output valid, kind, log_index, entry_term, entry_command, input ready);
  modport sink   (input valid, kind, log_index, entry_term, entry_command, output ready);
endinterface

interface rlf_out_if;
  import rlf_pkg::*;

  logic           valid;
  logic           ready;
  status_t        status;
  index_t         result_index;
  term_t          result_term;
  command_t       result_command;
  summary_index_t log_last_index;
  term_t          log_last_term;
  summary_index_t log_commit_index;

  modport source (output valid, status, result_index, result_term, result_command,
                  log_last_index, log_last_term, log_commit_index, input ready);
  modport sink   (input valid, status, result_index, result_term, result_command,
                  log_last_index, log_last_term, log_commit_index, output ready);
endinterface

@@ rtl/replicated_log_follower_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// replicated_log_follower_unit
// Follower side of a replicated consensus log: local appends, leader batches
// with conflict cut-back, commit advance and entry reads.
//
//   channel  dir  payload
//   req      in   kind, log_index, entry_term, entry_command
//   rsp      out  status, result_index/term/command, log last index/term, commit
//
// Each item passes through an issue phase in the back end, which reads the term
// and command stores at log_index - 1 (registered read), and then an execute
// phase, which checks and updates. The back end finishes one item before it
// starts the next, and execute waits while rsp holds an untaken result. A
// two-entry queue lets req keep accepting while rsp stalls, until the queue
// fills; the result register holds until taken.
// rst (synchronous) clears the log summary, commit point and batch state; the
// stores need no clearing since only written entries are ever read.
// ----------------------------------------------------------------------------
module replicated_log_follower_unit #(
  parameter int LOG_DEPTH    = 1024,
  parameter int COMMAND_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  rlf_in_if.sink    req,
  rlf_out_if.source rsp
);
  import rlf_pkg::*;

  logic  q_full;
  logic  q_push;
  item_t q_item;
  logic  q_pop;
  logic  head_valid;
  item_t head_item;

  rlf_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_item)
  );

  rlf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  rlf_back #(
    .LOG_DEPTH    (LOG_DEPTH),
    .COMMAND_BITS (COMMAND_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (q_pop),
    .rsp        (rsp)
  );

endmodule

@@ rtl/rlf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rlf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rlf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_front
// Accepts request beats and classifies them into operations for the queue.
// ----------------------------------------------------------------------------
module rlf_front (
  rlf_in_if.sink         req,
  input  logic           q_full,
  output logic           q_push,
  output rlf_pkg::item_t q_item
);
  import rlf_pkg::*;

  op_t op;

  always_comb begin
    unique case (req.kind)
      KIND_APPEND: op = OP_APPEND;
      KIND_HEADER: op = OP_HEADER;
      KIND_ENTRY:  op = OP_ENTRY;
      KIND_COMMIT: op = OP_COMMIT;
      KIND_READ:   op = OP_READ;
      default:     op = OP_NONE;
    endcase
  end

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  always_comb begin
    q_item.op            = op;
    q_item.idx_zero      = (req.log_index == '0);
    q_item.log_index     = req.log_index;
    q_item.idx_m1        = req.log_index - 16'd1;
    q_item.entry_term    = req.entry_term;
    q_item.entry_command = req.entry_command;
  end

endmodule

@@ rtl/rlf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rlf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rlf_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output rlf_pkg::item_t head_item
);
  import rlf_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule

@@ rtl/rlf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_back
// Carries out queued log operations against the term and command stores and
// holds the result register.
// ----------------------------------------------------------------------------
module rlf_back #(
  parameter int LOG_DEPTH    = 1024,
  parameter int COMMAND_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  rlf_pkg::item_t head_item,
  output logic           pop,
  rlf_out_if.source      rsp
);
  import rlf_pkg::*;

  localparam int TW = $clog2(LOG_DEPTH + 1);
  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = ((TW > 16) ? TW : 16) + 1;

  localparam logic PH_ISSUE = 1'b0;
  localparam logic PH_EXEC  = 1'b1;

  logic phase;
  logic phase_next;

  logic [TW-1:0] tail;
  logic [TW-1:0] tail_next;
  term_t         tail_term;
  term_t         tail_term_next;
  logic [TW-1:0] commit;
  logic [TW-1:0] commit_next;
  index_t        bprev;
  index_t        bprev_next;
  logic          healthy;
  logic          healthy_next;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           raddr;
  term_t                   rd_term;
  logic [COMMAND_BITS-1:0] rd_cmd;
  logic [COMMAND_BITS-1:0] cmd_st;
  logic [95:0]             cmd_in_wide;
  logic [COMMAND_BITS+31:0] cmd_st_wide;
  logic [COMMAND_BITS+31:0] cmd_rd_wide;

  logic [CW-1:0] idx_w;
  logic [CW-1:0] tail_w;
  logic [CW-1:0] tail_p1_w;
  logic [CW-1:0] commit_w;
  logic [CW-1:0] bprev_w;
  logic          full;
  logic          idx_le_tail;
  logic          room;
  logic          exec;

  status_t  st;
  index_t   r_idx;
  term_t    r_term;
  command_t r_cmd;

  rlf_ram #(.WIDTH(32), .DEPTH(LOG_DEPTH)) u_term_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (head_item.entry_term),
    .raddr (raddr),
    .rdata (rd_term)
  );

  rlf_ram #(.WIDTH(COMMAND_BITS), .DEPTH(LOG_DEPTH)) u_cmd_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd_st),
    .raddr (raddr),
    .rdata (rd_cmd)
  );

  assign raddr       = head_item.idx_m1[AW-1:0];
  assign cmd_in_wide = {64'd0, head_item.entry_command};
  assign cmd_st      = cmd_in_wide[COMMAND_BITS-1:0];
  assign cmd_st_wide = {32'd0, cmd_st};
  assign cmd_rd_wide = {32'd0, rd_cmd};

  assign idx_w       = {{(CW-16){1'b0}}, head_item.log_index};
  assign tail_w      = {{(CW-TW){1'b0}}, tail};
  assign tail_p1_w   = tail_w + {{(CW-1){1'b0}}, 1'b1};
  assign commit_w    = {{(CW-TW){1'b0}}, commit};
  assign bprev_w     = {{(CW-16){1'b0}}, bprev};
  assign full        = (tail_w >= CW'(LOG_DEPTH));
  assign idx_le_tail = (idx_w <= tail_w);

  assign room = !rsp.valid || rsp.ready;
  assign exec = (phase == PH_EXEC) && room;
  assign pop  = exec;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_ISSUE: if (head_valid) begin
        phase_next = PH_EXEC;
      end
      PH_EXEC: if (room) begin
        phase_next = PH_ISSUE;
      end
      default: phase_next = PH_ISSUE;
    endcase
  end

  always_comb begin
    st             = ST_OK;
    r_idx          = '0;
    r_term         = '0;
    r_cmd          = '0;
    we             = 1'b0;
    waddr          = head_item.idx_m1[AW-1:0];
    tail_next      = tail;
    tail_term_next = tail_term;
    commit_next    = commit;
    bprev_next     = bprev;
    healthy_next   = healthy;
    unique case (head_item.op)
      OP_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          we             = 1'b1;
          waddr          = tail[AW-1:0];
          tail_next      = tail_p1_w[TW-1:0];
          tail_term_next = head_item.entry_term;
          r_idx          = tail_p1_w[15:0];
          r_term         = head_item.entry_term;
          r_cmd          = cmd_st_wide[31:0];
        end
      end
      OP_HEADER: begin
        if (((head_item.idx_zero || !idx_le_tail) ? 32'd0 : rd_term)
            == head_item.entry_term) begin
          bprev_next   = head_item.log_index;
          healthy_next = 1'b1;
        end else begin
          st           = ST_PREV_MISMATCH;
          healthy_next = 1'b0;
        end
      end
      OP_ENTRY: begin
        priority if (!healthy) begin
          st = ST_SKIPPED;
        end else if (head_item.idx_zero) begin
          st           = ST_INDEX_ZERO;
          healthy_next = 1'b0;
        end else if (idx_w <= bprev_w) begin
          st           = ST_OVERLAP;
          healthy_next = 1'b0;
        end else if (idx_w > tail_p1_w) begin
          st           = ST_GAP;
          healthy_next = 1'b0;
        end else if (idx_le_tail && rd_term == head_item.entry_term) begin
          r_idx  = head_item.log_index;
          r_term = rd_term;
          r_cmd  = cmd_rd_wide[31:0];
        end else if (idx_le_tail && idx_w <= commit_w) begin
          st           = ST_REPLACE_COMMIT;
          healthy_next = 1'b0;
        end else if (!idx_le_tail && full) begin
          st           = ST_FULL;
          healthy_next = 1'b0;
        end else begin
          // cut back to the entry (or extend the log with it) and write it as the new tail
          we             = 1'b1;
          tail_next      = idx_w[TW-1:0];
          tail_term_next = head_item.entry_term;
          r_idx          = head_item.log_index;
          r_term         = head_item.entry_term;
          r_cmd          = cmd_st_wide[31:0];
        end
      end
      OP_COMMIT: begin
        priority if (idx_w < commit_w) begin
          st = ST_COMMIT_BACKWARD;
        end else if (!idx_le_tail) begin
          st = ST_COMMIT_PAST;
        end else begin
          commit_next = idx_w[TW-1:0];
        end
      end
      OP_READ: begin
        if (head_item.idx_zero || !idx_le_tail) begin
          st = ST_NOT_FOUND;
        end else begin
          r_idx  = head_item.log_index;
          r_term = rd_term;
          r_cmd  = cmd_rd_wide[31:0];
        end
      end
      default: st = ST_OK;
    endcase
    if (!exec) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_ISSUE;
      tail      <= '0;
      tail_term <= '0;
      commit    <= '0;
      bprev     <= '0;
      healthy   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (exec) begin
        tail      <= tail_next;
        tail_term <= tail_term_next;
        commit    <= commit_next;
        bprev     <= bprev_next;
        healthy   <= healthy_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  logic [CW-1:0] tail_next_w;
  logic [CW-1:0] commit_next_w;

  assign tail_next_w   = {{(CW-TW){1'b0}}, tail_next};
  assign commit_next_w = {{(CW-TW){1'b0}}, commit_next};

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp.status           <= st;
      rsp.result_index     <= r_idx;
      rsp.result_term      <= r_term;
      rsp.result_command   <= r_cmd;
      rsp.log_last_index   <= tail_next_w[10:0];
      rsp.log_last_term    <= tail_term_next;
      rsp.log_commit_index <= commit_next_w[10:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst) commit_w <= tail_w)
    else $error("commit point beyond last index");
  assert property (@(posedge clk) disable iff (rst) tail_w <= CW'(LOG_DEPTH))
    else $error("last index beyond log depth");
  assert property (@(posedge clk) disable iff (rst) (phase == PH_EXEC) |-> head_valid)
    else $error("execute phase without a queued item");
  assert property (@(posedge clk) disable iff (rst)
                   (rsp.valid && rsp.status != ST_OK) |-> (rsp.result_index == '0))
    else $error("error result carries an entry index");

endmodule
